>>> rtl/swap_victim_selector_assert.svh
// Assertion macros for the swap victim selector.
// Used by the top level only; defining SYNTH turns every macro into nothing.
`ifndef SWAP_VICTIM_SELECTOR_ASSERT_SVH
`define SWAP_VICTIM_SELECTOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SVS_ASSERT_NOW(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (b)) \
    else $error("svs assertion failed");
// Next-cycle implication.
`define SVS_ASSERT_NEXT(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (b)) \
    else $error("svs assertion failed");
`else
`define SVS_ASSERT_NOW(lbl, clk_s, rst_s, a, b)
`define SVS_ASSERT_NEXT(lbl, clk_s, rst_s, a, b)
`endif

`endif

>>> rtl/svs_pkg.sv
// Shared types and constants of the swap victim selector.
// No dependencies; used by svs_ctrl, svs_datapath and swap_victim_selector.
package svs_pkg;

  localparam int SLOTS     = 128;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = 7;
  localparam int USED_W    = 40;
  localparam int MB_W      = 20;
  localparam int TIME_W    = 64;
  localparam int PRIO_W    = 8;
  localparam int TOT_W     = 47;
  localparam int THR_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = THR_W + USED_W;
  localparam int CMP_W     = TOT_W + FRAC_W;
  localparam int MIB_SHIFT = 20;   // 1 MiB = 1024 * 1024 bytes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 40;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOTAL = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WR_READ, ST_WR_UPDATE, ST_P1_SCAN, ST_P1_DRAIN,
    ST_P2_SCAN, ST_P2_DRAIN, ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic wr_read;
    logic wr_commit;
    logic p1_issue;
    logic p2_issue;
    logic cnt_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

  typedef struct packed {
    logic [USED_W-1:0] used;
    logic [MB_W-1:0]   req;
    logic [MB_W-1:0]   lim;
    logic              swapped;
    logic [TIME_W-1:0] run_time;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

>>> rtl/svs_ctrl.sv
// Sequencer of the swap victim selector: write and two-pass select flows.
// Depends on svs_pkg.
module svs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          opcode,
  input  svs_pkg::sts_t sts,
  output svs_pkg::cmd_t cmd,
  output logic          busy
);

  svs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= svs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      svs_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (opcode == svs_pkg::OP_WRITE) ? svs_pkg::ST_WR_READ
                                                     : svs_pkg::ST_P1_SCAN;
        end
      end
      svs_pkg::ST_WR_READ: begin
        cmd.wr_read = 1'b1;
        state_next  = svs_pkg::ST_WR_UPDATE;
      end
      svs_pkg::ST_WR_UPDATE: begin
        cmd.wr_commit = 1'b1;
        state_next    = svs_pkg::ST_RESULT;
      end
      svs_pkg::ST_P1_SCAN: begin
        cmd.p1_issue = 1'b1;
        if (sts.scan_last) state_next = svs_pkg::ST_P1_DRAIN;
      end
      svs_pkg::ST_P1_DRAIN: begin
        cmd.cnt_clr = 1'b1;
        state_next  = svs_pkg::ST_P2_SCAN;
      end
      svs_pkg::ST_P2_SCAN: begin
        cmd.p2_issue = 1'b1;
        if (sts.scan_last) state_next = svs_pkg::ST_P2_DRAIN;
      end
      svs_pkg::ST_P2_DRAIN: state_next = svs_pkg::ST_RESULT;
      svs_pkg::ST_RESULT: begin
        cmd.emit   = 1'b1;
        state_next = svs_pkg::ST_IDLE;
      end
      default: state_next = svs_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != svs_pkg::ST_IDLE);

endmodule

>>> rtl/svs_datapath.sv
// Datapath of the swap victim selector: slot memory, scan logic, watermark.
// Depends on svs_pkg; driven by svs_ctrl commands.
module svs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  svs_pkg::cmd_t                 cmd,
  output svs_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [svs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svs_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          opcode,
  input  logic [6:0]                    entry_index,
  input  logic                          allocated,
  input  logic [svs_pkg::USED_W-1:0]    mem_used,
  input  logic [svs_pkg::MB_W-1:0]      request_mb,
  input  logic [svs_pkg::MB_W-1:0]      limit_mb,
  input  logic                          swapped_out,
  input  logic [svs_pkg::TIME_W-1:0]    last_run_time,
  input  logic [svs_pkg::PRIO_W-1:0]    evict_prio,
  input  logic                          borrowed_only,
  output logic                          done,
  output logic                          status,
  output logic [6:0]                    victim_index,
  output logic [svs_pkg::USED_W-1:0]    victim_mem_used,
  output logic [svs_pkg::CNT_W-1:0]     candidate_count,
  output logic                          pre_swap
);

  localparam int IW = svs_pkg::IDX_W;

  // configuration and watermark product
  logic [svs_pkg::THR_W-1:0]  threshold;
  logic [svs_pkg::USED_W-1:0] mem_total;
  logic [svs_pkg::PROD_W-1:0] limit_prod;
  logic [svs_pkg::TOT_W-1:0]  used_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= svs_pkg::THR_RESET;
      mem_total <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svs_pkg::CFG_THRESHOLD: threshold <= cfg_wdata[svs_pkg::THR_W-1:0];
        svs_pkg::CFG_MEM_TOTAL: mem_total <= cfg_wdata[svs_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_prod <= svs_pkg::PROD_W'(threshold) * svs_pkg::PROD_W'(mem_total);
  end

  // latched request
  logic              op, borrowed, w_ok, w_alloc;
  logic [IW-1:0]     w_idx;
  svs_pkg::entry_t   w_entry;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= opcode;
      borrowed <= borrowed_only;
      w_ok     <= ({1'b0, entry_index} < 8'(svs_pkg::SLOTS));
      w_idx    <= entry_index[IW-1:0];
      w_alloc  <= allocated;
      w_entry  <= '{used: mem_used, req: request_mb, lim: limit_mb,
                    swapped: swapped_out, run_time: last_run_time,
                    prio: evict_prio};
    end
  end

  // slot memory and allocation bits
  svs_pkg::entry_t mem [svs_pkg::SLOTS];
  svs_pkg::entry_t rdata;
  logic [IW-1:0]   raddr;
  logic [svs_pkg::SLOTS-1:0] slot_alloc;
  logic            mem_we;

  assign mem_we = cmd.wr_commit && w_ok;

  always_ff @(posedge clk) begin
    if (mem_we) mem[w_idx] <= w_entry;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_alloc <= '0;
      used_bytes <= '0;
    end else if (mem_we) begin
      slot_alloc[w_idx] <= w_alloc;
      used_bytes <= used_bytes
                    - (slot_alloc[w_idx] ? svs_pkg::TOT_W'(rdata.used) : '0)
                    + (w_alloc ? svs_pkg::TOT_W'(w_entry.used) : '0);
    end
  end

  // scan counter and read address
  logic [IW-1:0] cnt;
  logic [IW-1:0] newest, last_idx;
  logic [IW-1:0] p2_slot;
  logic          p2_eval;

  assign sts.scan_last = (cnt == IW'(svs_pkg::SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.cnt_clr)             cnt <= '0;
    else if (cmd.p1_issue || cmd.p2_issue) cnt <= cnt + 1'b1;
  end

  // Second pass: the last allocated slot stands in the newest slot's place.
  assign p2_slot = (cnt == newest && cnt != last_idx) ? last_idx : cnt;
  assign p2_eval = slot_alloc[p2_slot] && (cnt != last_idx);

  always_comb begin
    if (cmd.wr_read)       raddr = w_idx;
    else if (cmd.p2_issue) raddr = p2_slot;
    else                   raddr = cnt;
  end

  logic          tag_v1, tag_v2;
  logic [IW-1:0] tag_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_v1 <= 1'b0;
      tag_v2 <= 1'b0;
    end else begin
      tag_v1 <= cmd.p1_issue && slot_alloc[cnt];
      tag_v2 <= cmd.p2_issue && p2_eval;
    end
  end

  always_ff @(posedge clk) begin
    tag_idx <= cmd.p2_issue ? p2_slot : cnt;
  end

  // pass one: newest run time (first on ties) and last allocated slot
  logic                      found;
  logic [svs_pkg::TIME_W-1:0] newest_time;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found    <= 1'b0;
      newest   <= '0;
      last_idx <= '0;
    end else if (tag_v1) begin
      last_idx <= tag_idx;
      if (!found || rdata.run_time > newest_time) begin
        found       <= 1'b1;
        newest      <= tag_idx;
        newest_time <= rdata.run_time;
      end
    end
  end

  // pass two: filter and rank
  logic                       pass_ok, better;
  logic                       have;
  logic [IW-1:0]              lead_idx;
  logic [svs_pkg::USED_W-1:0] best_used;
  logic [svs_pkg::PRIO_W-1:0] best_prio;
  logic [svs_pkg::TIME_W-1:0] best_time;
  logic [svs_pkg::CNT_W-1:0]  ncand;

  assign pass_ok = (rdata.used != '0) && !rdata.swapped && (rdata.req != rdata.lim)
                   && !(borrowed &&
                        rdata.used <= {rdata.req, svs_pkg::MIB_SHIFT'(0)});
  assign better  = !have || (rdata.prio > best_prio) ||
                   (rdata.prio == best_prio && rdata.run_time < best_time);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      have  <= 1'b0;
      ncand <= '0;
    end else if (tag_v2 && pass_ok) begin
      ncand <= ncand + 1'b1;
      if (better) begin
        have      <= 1'b1;
        lead_idx  <= tag_idx;
        best_used <= rdata.used;
        best_prio <= rdata.prio;
        best_time <= rdata.run_time;
      end
    end
  end

  // result register
  logic wm_hit;
  assign wm_hit = (mem_total != '0) &&
                  ({used_bytes, svs_pkg::FRAC_W'(0)} >= svs_pkg::CMP_W'(limit_prod));

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pre_swap <= wm_hit;
      if (op == svs_pkg::OP_SELECT && have) begin
        status          <= 1'b0;
        victim_index    <= 7'(lead_idx);
        victim_mem_used <= best_used;
        candidate_count <= ncand;
      end else begin
        status          <= (op == svs_pkg::OP_SELECT);
        victim_index    <= '0;
        victim_mem_used <= '0;
        candidate_count <= '0;
      end
    end
  end

endmodule

>>> rtl/swap_victim_selector.sv
// Top level of the swap victim selector: sequencer plus datapath.
// Depends on svs_pkg, svs_ctrl, svs_datapath, swap_victim_selector_assert.svh.
//
//  channel   strobe          payload
//  request   start & !busy   opcode, entry_index, allocated, mem_used, request_mb,
//                            limit_mb, swapped_out, last_run_time, evict_prio,
//                            borrowed_only
//  result    done (1 cycle)  status, victim_index, victim_mem_used,
//                            candidate_count, pre_swap
//  config    cfg_we          cfg_index, cfg_wdata (no wait, no read-back)
//
// A write request reads the old slot from memory, updates it and then
// registers the result. A select request is bound by the single read port of
// the slot memory walked twice: once for the newest run time, once to filter
// and rank. Reset is synchronous and clears allocation bits and the used
// total; no clearing pass is needed. Results cannot be stalled; busy holds
// off the next request until the current result has been registered.
`include "swap_victim_selector_assert.svh"

module swap_victim_selector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [svs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svs_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          opcode,
  input  logic [6:0]                    entry_index,
  input  logic                          allocated,
  input  logic [svs_pkg::USED_W-1:0]    mem_used,
  input  logic [svs_pkg::MB_W-1:0]      request_mb,
  input  logic [svs_pkg::MB_W-1:0]      limit_mb,
  input  logic                          swapped_out,
  input  logic [svs_pkg::TIME_W-1:0]    last_run_time,
  input  logic [svs_pkg::PRIO_W-1:0]    evict_prio,
  input  logic                          borrowed_only,
  output logic                          done,
  output logic                          status,
  output logic [6:0]                    victim_index,
  output logic [svs_pkg::USED_W-1:0]    victim_mem_used,
  output logic [svs_pkg::CNT_W-1:0]     candidate_count,
  output logic                          pre_swap
);

  svs_pkg::cmd_t cmd;
  svs_pkg::sts_t sts;

  // Sequence the write and select flows.
  svs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold slot table, scan state, config and the result register.
  svs_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .opcode          (opcode),
    .entry_index     (entry_index),
    .allocated       (allocated),
    .mem_used        (mem_used),
    .request_mb      (request_mb),
    .limit_mb        (limit_mb),
    .swapped_out     (swapped_out),
    .last_run_time   (last_run_time),
    .evict_prio      (evict_prio),
    .borrowed_only   (borrowed_only),
    .done            (done),
    .status          (status),
    .victim_index    (victim_index),
    .victim_mem_used (victim_mem_used),
    .candidate_count (candidate_count),
    .pre_swap        (pre_swap)
  );

  // A "no victim" result carries zero index and count.
  `SVS_ASSERT_NOW(a_none_zero, clk, rst, done && status, victim_index == '0 && candidate_count == '0)
  // An accepted request makes the block busy.
  `SVS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // The result strobe only follows the end of a flow.
  `SVS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

endmodule
